/* src/triangle_box_overlap_test_top_assert.svh */
// Assertion macros for the triangle/box overlap block
`ifndef TRIANGLE_BOX_OVERLAP_TEST_TOP_ASSERT_SVH
`define TRIANGLE_BOX_OVERLAP_TEST_TOP_ASSERT_SVH

// same-cycle implication
`define TBO_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("tbo assertion failed");

// implication after a fixed number of cycles
`define TBO_ASSERT_DLY(lbl, clk_s, rstn_s, ante, n, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> ##(n) (cons)) \
    else $error("tbo delayed assertion failed");

`endif

/* src/tbo_pkg.sv */
// Shared types, widths and helpers for the triangle/box overlap block
`default_nettype none
package tbo_pkg;

  localparam int COORD_W = 24;
  localparam int HALF_W  = COORD_W - 1;
  localparam int V_W     = COORD_W + 1;          // vertex relative to centre
  localparam int F_W     = COORD_W + 2;          // triangle edge
  localparam int FA_W    = COORD_W + 1;          // magnitude of an edge component
  localparam int EP_W    = V_W + F_W;            // one edge-axis product
  localparam int ED_W    = EP_W + 1;             // edge-axis projection
  localparam int ER_W    = HALF_W + FA_W + 1;    // edge-axis box radius
  localparam int PN_W    = 2 * F_W + 1;          // normal component
  localparam int PA_W    = 2 * F_W;              // normal component magnitude
  localparam int LO_W    = F_W;                  // split point of the normal
  localparam int PH_W    = PN_W - LO_W;
  localparam int PP_W    = PH_W + V_W;           // partial product of n.v0
  localparam int RL_W    = HALF_W + LO_W;
  localparam int RH_W    = HALF_W + PA_W - LO_W;
  localparam int ND_W    = PN_W + V_W + 2;       // n.v0
  localparam int NR_W    = HALF_W + PA_W + 2;    // normal-axis box radius
  localparam int FRAC_BITS = 16;
  localparam int Q_W     = FRAC_BITS + 1;
  localparam int NUM_W   = ND_W + FRAC_BITS;
  localparam logic [Q_W-1:0] FRAC_ONE = Q_W'(1) << FRAC_BITS;
  localparam int PRE_STAGES = 7;
  localparam int LATENCY = PRE_STAGES + Q_W + 1;

  typedef enum logic [1:0] {
    REG_HALF_X = 2'd0,
    REG_HALF_Y = 2'd1,
    REG_HALF_Z = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] vert0_x;
    logic signed [COORD_W-1:0] vert0_y;
    logic signed [COORD_W-1:0] vert0_z;
    logic signed [COORD_W-1:0] vert1_x;
    logic signed [COORD_W-1:0] vert1_y;
    logic signed [COORD_W-1:0] vert1_z;
    logic signed [COORD_W-1:0] vert2_x;
    logic signed [COORD_W-1:0] vert2_y;
    logic signed [COORD_W-1:0] vert2_z;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
  } in_t;

  typedef struct packed {
    logic           separated;
    logic [Q_W-1:0] hit_fraction;
  } out_t;

  typedef struct packed {
    logic vld;
    logic sep;
    logic zero;
  } div_tag_t;

  function automatic int nxt3(input int i);
    return (i == 2) ? 0 : i + 1;
  endfunction

endpackage
`default_nettype wire

/* src/triangle_box_overlap_test_top.sv */
// Triangle versus axis-aligned box separating-axis test, top level
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------
//  in       | start / busy       | in_data  (tbo_pkg::in_t)
//  out      | out_valid strobe   | out_data (tbo_pkg::out_t)
//  cfg      | cfg_we, cfg_index  | cfg_data (box half extents)
//
// One transfer accepted every cycle; busy is never raised.
// A result passes through seven arithmetic stages, then one stage per
// quotient bit of the fraction divider, then the output register.
// Synchronous active-low reset clears valid bits and the half-size registers.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none
module triangle_box_overlap_test_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire tbo_pkg::in_t                  in_data,
  output logic                               out_valid,
  output tbo_pkg::out_t                      out_data,
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [tbo_pkg::HALF_W-1:0]    cfg_data
);

  localparam int V_W  = tbo_pkg::V_W;
  localparam int F_W  = tbo_pkg::F_W;
  localparam int FA_W = tbo_pkg::FA_W;
  localparam int EP_W = tbo_pkg::EP_W;
  localparam int ED_W = tbo_pkg::ED_W;
  localparam int ER_W = tbo_pkg::ER_W;
  localparam int PN_W = tbo_pkg::PN_W;
  localparam int PA_W = tbo_pkg::PA_W;
  localparam int LO_W = tbo_pkg::LO_W;
  localparam int PP_W = tbo_pkg::PP_W;
  localparam int RL_W = tbo_pkg::RL_W;
  localparam int RH_W = tbo_pkg::RH_W;
  localparam int ND_W = tbo_pkg::ND_W;
  localparam int NR_W = tbo_pkg::NR_W;
  localparam int HW   = tbo_pkg::HALF_W;

  // ---------------- configuration
  logic [HW-1:0] half_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) half_r[k] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tbo_pkg::REG_HALF_X: half_r[0] <= cfg_data;
        tbo_pkg::REG_HALF_Y: half_r[1] <= cfg_data;
        tbo_pkg::REG_HALF_Z: half_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // ---------------- stage 1: vertices relative to centre
  logic signed [tbo_pkg::COORD_W-1:0] cin [4][3];
  logic signed [V_W-1:0] v1_nxt [3][3];
  logic signed [V_W-1:0] v1_r   [3][3];
  logic                  vld1_r;

  always_comb begin
    cin[0][0] = in_data.vert0_x; cin[0][1] = in_data.vert0_y; cin[0][2] = in_data.vert0_z;
    cin[1][0] = in_data.vert1_x; cin[1][1] = in_data.vert1_y; cin[1][2] = in_data.vert1_z;
    cin[2][0] = in_data.vert2_x; cin[2][1] = in_data.vert2_y; cin[2][2] = in_data.vert2_z;
    cin[3][0] = in_data.center_x; cin[3][1] = in_data.center_y;
    cin[3][2] = in_data.center_z;
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++)
        v1_nxt[i][k] = V_W'(cin[i][k]) - V_W'(cin[3][k]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld1_r <= 1'b0;
    else        vld1_r <= start && !busy;
    v1_r <= v1_nxt;
  end

  // ---------------- stage 2: edges, their magnitudes, box-face axes
  logic signed [F_W-1:0]  f2_nxt [3][3];
  logic        [FA_W-1:0] fa2_nxt [3][3];
  logic                   sep2_nxt;
  logic signed [F_W-1:0]  f2_r [3][3];
  logic        [FA_W-1:0] fa2_r [3][3];
  logic signed [V_W-1:0]  v2_r [3][3];
  logic                   vld2_r, sep2_r;

  always_comb begin
    logic signed [V_W-1:0] mx, mn, hs;
    logic signed [F_W-1:0] fneg;
    sep2_nxt = 1'b0;
    for (int e = 0; e < 3; e++)
      for (int k = 0; k < 3; k++) begin
        f2_nxt[e][k] = F_W'(v1_r[tbo_pkg::nxt3(e)][k]) - F_W'(v1_r[e][k]);
        fneg = -f2_nxt[e][k];
        fa2_nxt[e][k] = f2_nxt[e][k][F_W-1] ? FA_W'(fneg) : FA_W'(f2_nxt[e][k]);
      end
    for (int k = 0; k < 3; k++) begin
      mx = v1_r[0][k];
      mn = v1_r[0][k];
      for (int i = 1; i < 3; i++) begin
        if (v1_r[i][k] > mx) mx = v1_r[i][k];
        if (v1_r[i][k] < mn) mn = v1_r[i][k];
      end
      hs = $signed({2'b00, half_r[k]});
      if ((mx < -hs) || (mn > hs)) sep2_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld2_r <= 1'b0;
    else        vld2_r <= vld1_r;
    f2_r   <= f2_nxt;
    fa2_r  <= fa2_nxt;
    v2_r   <= v1_r;
    sep2_r <= sep2_nxt;
  end

  // ---------------- stage 3: edge-axis projections and radii, normal
  logic signed [ED_W-1:0] ed3_nxt [3][3][3];
  logic        [ER_W-1:0] er3_nxt [3][3];
  logic signed [PN_W-1:0] pn3_nxt [3];
  logic signed [ED_W-1:0] ed3_r [3][3][3];
  logic        [ER_W-1:0] er3_r [3][3];
  logic signed [PN_W-1:0] pn3_r [3];
  logic signed [V_W-1:0]  v03_r [3];
  logic                   vld3_r, sep3_r;

  always_comb begin
    logic signed [EP_W-1:0]    pa, pb;
    logic signed [2*F_W-1:0]   na, nb;
    logic        [ER_W-1:0]    ra, rb;
    int a, b;
    for (int k = 0; k < 3; k++) begin
      a = tbo_pkg::nxt3(k);
      b = tbo_pkg::nxt3(a);
      for (int e = 0; e < 3; e++) begin
        for (int i = 0; i < 3; i++) begin
          pa = v2_r[i][b] * f2_r[e][a];
          pb = v2_r[i][a] * f2_r[e][b];
          ed3_nxt[k][e][i] = ED_W'(pa) - ED_W'(pb);
        end
        ra = ER_W'(half_r[a]) * ER_W'(fa2_r[e][b]);
        rb = ER_W'(half_r[b]) * ER_W'(fa2_r[e][a]);
        er3_nxt[k][e] = ra + rb;
      end
    end
    for (int k = 0; k < 3; k++) begin
      a = tbo_pkg::nxt3(k);
      b = tbo_pkg::nxt3(a);
      na = f2_r[0][a] * f2_r[1][b];
      nb = f2_r[0][b] * f2_r[1][a];
      pn3_nxt[k] = PN_W'(na) - PN_W'(nb);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld3_r <= 1'b0;
    else        vld3_r <= vld2_r;
    ed3_r  <= ed3_nxt;
    er3_r  <= er3_nxt;
    pn3_r  <= pn3_nxt;
    v03_r  <= v2_r[0];
    sep3_r <= sep2_r;
  end

  // ---------------- stage 4: edge-axis verdict, normal magnitude
  logic                   sep4_nxt;
  logic        [PA_W-1:0] pa4_nxt [3];
  logic signed [PN_W-1:0] pn4_r [3];
  logic        [PA_W-1:0] pa4_r [3];
  logic signed [V_W-1:0]  v04_r [3];
  logic                   vld4_r, sep4_r;

  always_comb begin
    logic signed [ED_W-1:0] mx, mn, rs;
    logic signed [PN_W-1:0] pneg;
    sep4_nxt = sep3_r;
    for (int k = 0; k < 3; k++)
      for (int e = 0; e < 3; e++) begin
        mx = ed3_r[k][e][0];
        mn = ed3_r[k][e][0];
        for (int i = 1; i < 3; i++) begin
          if (ed3_r[k][e][i] > mx) mx = ed3_r[k][e][i];
          if (ed3_r[k][e][i] < mn) mn = ed3_r[k][e][i];
        end
        rs = $signed(ED_W'(er3_r[k][e]));
        if ((mx < -rs) || (mn > rs)) sep4_nxt = 1'b1;
      end
    for (int k = 0; k < 3; k++) begin
      pneg = -pn3_r[k];
      pa4_nxt[k] = pn3_r[k][PN_W-1] ? PA_W'(pneg) : PA_W'(pn3_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld4_r <= 1'b0;
    else        vld4_r <= vld3_r;
    pn4_r  <= pn3_r;
    pa4_r  <= pa4_nxt;
    v04_r  <= v03_r;
    sep4_r <= sep4_nxt;
  end

  // ---------------- stage 5: split products for n.v0 and the normal radius
  logic signed [PP_W-1:0] ppl5_r [3];
  logic signed [PP_W-1:0] pph5_r [3];
  logic        [RL_W-1:0] rl5_r [3];
  logic        [RH_W-1:0] rh5_r [3];
  logic                   vld5_r, sep5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld5_r <= 1'b0;
    else        vld5_r <= vld4_r;
    for (int k = 0; k < 3; k++) begin
      ppl5_r[k] <= $signed({1'b0, pn4_r[k][LO_W-1:0]}) * v04_r[k];
      pph5_r[k] <= $signed(pn4_r[k][PN_W-1:LO_W]) * v04_r[k];
      rl5_r[k]  <= RL_W'(half_r[k]) * RL_W'(pa4_r[k][LO_W-1:0]);
      rh5_r[k]  <= RH_W'(half_r[k]) * RH_W'(pa4_r[k][PA_W-1:LO_W]);
    end
    sep5_r <= sep4_r;
  end

  // ---------------- stage 6: recombine partial products
  logic signed [ND_W-1:0] nd6_nxt, nd6_r;
  logic        [NR_W-1:0] nr6_nxt, nr6_r;
  logic                   vld6_r, sep6_r;

  always_comb begin
    nd6_nxt = '0;
    nr6_nxt = '0;
    for (int k = 0; k < 3; k++) begin
      nd6_nxt = nd6_nxt + (ND_W'(pph5_r[k]) <<< LO_W) + ND_W'(ppl5_r[k]);
      nr6_nxt = nr6_nxt + (NR_W'(rh5_r[k]) << LO_W) + NR_W'(rl5_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld6_r <= 1'b0;
    else        vld6_r <= vld5_r;
    nd6_r  <= nd6_nxt;
    nr6_r  <= nr6_nxt;
    sep6_r <= sep5_r;
  end

  // ---------------- stage 7: plane distance, normal-axis verdict
  logic        [ND_W-1:0]           pd7;
  logic signed [ND_W-1:0]           ndneg;
  tbo_pkg::div_tag_t                tag7_nxt, tag7_r;
  logic [tbo_pkg::NUM_W-1:0]        num7_r;
  logic [NR_W-1:0]                  den7_r;

  always_comb begin
    ndneg = -nd6_r;
    pd7   = nd6_r[ND_W-1] ? $unsigned(ndneg) : $unsigned(nd6_r);
    tag7_nxt.vld  = vld6_r;
    tag7_nxt.sep  = sep6_r || (ND_W'(nr6_r) < pd7);
    tag7_nxt.zero = (nr6_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag7_r.vld <= 1'b0;
    end else begin
      tag7_r <= tag7_nxt;
    end
    num7_r <= {pd7, {tbo_pkg::FRAC_BITS{1'b0}}};
    den7_r <= nr6_r;
  end

  // ---------------- fraction divider
  tbo_pkg::div_tag_t          dtag;
  logic [tbo_pkg::Q_W-1:0]    dquo;

  tbo_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_tag  (tag7_r),
    .in_num  (num7_r),
    .in_den  (den7_r),
    .out_tag (dtag),
    .out_quo (dquo)
  );

  // ---------------- output register
  logic          out_valid_r;
  tbo_pkg::out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= dtag.vld;
    out_data_r.separated <= dtag.sep;
    if (dtag.sep)       out_data_r.hit_fraction <= tbo_pkg::FRAC_ONE;
    else if (dtag.zero) out_data_r.hit_fraction <= '0;  // zero radius, zero distance
    else                out_data_r.hit_fraction <= dquo;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

/* src/tbo_div.sv */
// Pipelined restoring divider: one quotient bit per stage
`default_nettype none
module tbo_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire tbo_pkg::div_tag_t            in_tag,
  input  wire logic [tbo_pkg::NUM_W-1:0]    in_num,
  input  wire logic [tbo_pkg::NR_W-1:0]     in_den,
  output tbo_pkg::div_tag_t                 out_tag,
  output logic [tbo_pkg::Q_W-1:0]           out_quo
);

  localparam int NS = tbo_pkg::Q_W;

  tbo_pkg::div_tag_t             tag_i [NS];
  logic [tbo_pkg::NUM_W-1:0]     num_i [NS];
  logic [tbo_pkg::NR_W-1:0]      den_i [NS];
  logic [tbo_pkg::Q_W-1:0]       quo_i [NS];

  tbo_pkg::div_tag_t             tag_r [NS];
  logic [tbo_pkg::NUM_W-1:0]     num_r [NS];
  logic [tbo_pkg::NR_W-1:0]      den_r [NS];
  logic [tbo_pkg::Q_W-1:0]       quo_r [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int B = NS - 1 - s;
    logic [tbo_pkg::NUM_W-1:0] dsh;
    logic                      ge;
    logic [tbo_pkg::NUM_W-1:0] num_nxt;
    logic [tbo_pkg::Q_W-1:0]   quo_nxt;

    if (s == 0) begin : g_first
      assign tag_i[s] = in_tag;
      assign num_i[s] = in_num;
      assign den_i[s] = in_den;
      assign quo_i[s] = '0;
    end else begin : g_rest
      assign tag_i[s] = tag_r[s-1];
      assign num_i[s] = num_r[s-1];
      assign den_i[s] = den_r[s-1];
      assign quo_i[s] = quo_r[s-1];
    end

    assign dsh     = tbo_pkg::NUM_W'(den_i[s]) << B;
    assign ge      = (num_i[s] >= dsh);
    assign num_nxt = ge ? (num_i[s] - dsh) : num_i[s];
    assign quo_nxt = quo_i[s] | (tbo_pkg::Q_W'(ge) << B);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[s].vld <= 1'b0;
      end else begin
        tag_r[s] <= tag_i[s];
      end
      num_r[s] <= num_nxt;
      den_r[s] <= den_i[s];
      quo_r[s] <= quo_nxt;
    end
  end

  assign out_tag = tag_r[NS-1];
  assign out_quo = quo_r[NS-1];

endmodule
`default_nettype wire

/* src/tbo_chk.sv */
// Port-level checker for the triangle/box overlap block, with its bind
`default_nettype none
`include "triangle_box_overlap_test_top_assert.svh"
module tbo_chk (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          out_valid,
  input wire tbo_pkg::out_t out_data
);

  logic                      sep_out;
  logic [tbo_pkg::Q_W-1:0]   frac_out;

  assign sep_out  = out_data.separated;
  assign frac_out = out_data.hit_fraction;

  `TBO_ASSERT_DLY(a_result_follows, clk, rst_n, start && !busy, tbo_pkg::LATENCY, out_valid)
  `TBO_ASSERT_IMP(a_no_orphan, clk, rst_n, out_valid, $past(start && !busy, tbo_pkg::LATENCY))
  `TBO_ASSERT_IMP(a_sep_is_one, clk, rst_n, out_valid && sep_out, frac_out == tbo_pkg::FRAC_ONE)
  `TBO_ASSERT_IMP(a_frac_range, clk, rst_n, out_valid, frac_out <= tbo_pkg::FRAC_ONE)

endmodule

bind triangle_box_overlap_test_top tbo_chk u_tbo_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
`default_nettype wire
